### sv/clock_page_replacement_unit_assert.svh
// assertion macros for the clock page replacement unit
// used by cpr_ctrl and cpr_datapath, no other dependencies
`ifndef CLOCK_PAGE_REPLACEMENT_UNIT_ASSERT_SVH
`define CLOCK_PAGE_REPLACEMENT_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CPR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpr assertion failed");

// next-cycle implication, disabled in reset
`define CPR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpr assertion failed");

`endif

### sv/cpr_pkg.sv
// shared types and constants of the clock page replacement unit
// no dependencies
package cpr_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int PAGE_W     = 8;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int FAULT_W    = 32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_SWEEP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_req;    // capture the request
        logic hit_commit;  // mark hit frame, load result
        logic sweep_start; // place the scan pointer at the hand, or at frame 0 if the hand is out of range
        logic sweep_step;  // clear reference bit, advance scan
        logic fill;        // replace frame at scan, load result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic scan_ref;
    } t_sts;

endpackage

### sv/cpr_intf.sv
// request and result channel interfaces
// depends on cpr_pkg
interface cpr_req_if import cpr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page;
    logic              last;

    modport source (output valid, page, last, input ready);
    modport sink   (input valid, page, last, output ready);
endinterface

interface cpr_rsp_if import cpr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               fault;
    logic [FRAME_W-1:0] frame;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic               evicted_dirty;
    logic [FAULT_W-1:0] fault_total;
    logic               last_out;

    modport source (output valid, fault, frame, evicted_valid, evicted_page,
                    evicted_dirty, fault_total, last_out, input ready);
    modport sink   (input valid, fault, frame, evicted_valid, evicted_page,
                    evicted_dirty, fault_total, last_out, output ready);
endinterface

### sv/cpr_datapath.sv
// frame store, clock hand, fault counter and result register
// depends on cpr_pkg and the assertion macro header
`include "clock_page_replacement_unit_assert.svh"

module cpr_datapath import cpr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CNT_W-1:0]   i_cfg_wdata,
    input  logic [PAGE_W-1:0]  i_page,
    input  logic               i_last,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic               o_fault,
    output logic [FRAME_W-1:0] o_frame,
    output logic               o_evicted_valid,
    output logic [PAGE_W-1:0]  o_evicted_page,
    output logic               o_evicted_dirty,
    output logic [FAULT_W-1:0] o_fault_total,
    output logic               o_last_out
);

    logic [CNT_W-1:0]   r_frames;
    logic [PAGE_W-1:0]  r_page;
    logic               r_last;
    logic [PAGE_W-1:0]  r_pg    [MAX_FRAMES];
    logic               r_valid [MAX_FRAMES];
    logic               r_ref   [MAX_FRAMES];
    logic               r_dirty [MAX_FRAMES];
    logic [FRAME_W-1:0] r_hand;
    logic [FRAME_W-1:0] r_scan;
    logic [FAULT_W-1:0] r_cnt;

    logic               r_fault;
    logic [FRAME_W-1:0] r_frame;
    logic               r_ev_valid;
    logic [PAGE_W-1:0]  r_ev_page;
    logic               r_ev_dirty;
    logic [FAULT_W-1:0] r_total;
    logic               r_last_out;

    logic [CNT_W-1:0]   n_act;
    logic               hit;
    logic [FRAME_W-1:0] hit_idx;
    logic [FRAME_W-1:0] scan_inc;
    logic [FAULT_W-1:0] cnt_inc;

    // clamp the frame count to 1..MAX_FRAMES
    always_comb begin
        n_act = r_frames;
        if (r_frames == '0) begin
            n_act = CNT_W'(1);
        end else if (r_frames > CNT_W'(MAX_FRAMES)) begin
            n_act = CNT_W'(MAX_FRAMES);
        end
    end

    // parallel match, lowest frame wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_pg[i] == r_page && CNT_W'(i) < n_act) begin
                hit     = 1'b1;
                hit_idx = FRAME_W'(i);
            end
        end
    end

    assign scan_inc = (CNT_W'(r_scan) + CNT_W'(1) == n_act) ? '0 : r_scan + FRAME_W'(1);
    assign cnt_inc  = (&r_cnt) ? r_cnt : r_cnt + FAULT_W'(1);

    assign o_sts.hit      = hit;
    assign o_sts.scan_ref = r_ref[r_scan];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= CNT_W'(MAX_FRAMES);
            r_hand   <= '0;
            r_cnt    <= '0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_valid[i] <= 1'b0;
                r_ref[i]   <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_frames <= i_cfg_wdata;
            end
            if (i_cmd.hit_commit) begin
                r_ref[hit_idx] <= 1'b1;
            end
            if (i_cmd.sweep_step) begin
                r_ref[r_scan] <= 1'b0;
            end
            if (i_cmd.fill) begin
                r_valid[r_scan] <= 1'b1;
                r_ref[r_scan]   <= 1'b1;
                r_hand          <= scan_inc;
                r_cnt           <= cnt_inc;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_page <= i_page;
            r_last <= i_last;
        end
        if (i_cmd.sweep_start) begin
            r_scan <= (CNT_W'(r_hand) >= n_act) ? '0 : r_hand;
        end else if (i_cmd.sweep_step) begin
            r_scan <= scan_inc;
        end
        if (i_cmd.hit_commit) begin
            r_dirty[hit_idx] <= 1'b1;
            r_fault          <= 1'b0;
            r_frame          <= hit_idx;
            r_ev_valid       <= 1'b0;
            r_ev_page        <= '0;
            r_ev_dirty       <= 1'b0;
            r_total          <= r_cnt;
            r_last_out       <= r_last;
        end
        if (i_cmd.fill) begin
            r_pg[r_scan]    <= r_page;
            r_dirty[r_scan] <= 1'b0;
            r_fault         <= 1'b1;
            r_frame         <= r_scan;
            r_ev_valid      <= r_valid[r_scan];
            r_ev_page       <= r_valid[r_scan] ? r_pg[r_scan] : '0;
            r_ev_dirty      <= r_valid[r_scan] & r_dirty[r_scan];
            r_total         <= cnt_inc;
            r_last_out      <= r_last;
        end
    end

    assign o_fault         = r_fault;
    assign o_frame         = r_frame;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_evicted_dirty = r_ev_dirty;
    assign o_fault_total   = r_total;
    assign o_last_out      = r_last_out;

    `CPR_ASSERT_IMP(a_scan_in_range, i_clk, i_rst_n, i_cmd.sweep_step || i_cmd.fill, CNT_W'(r_scan) < n_act)
    `CPR_ASSERT_IMP(a_fill_unreferenced, i_clk, i_rst_n, i_cmd.fill, !r_ref[r_scan])
    `CPR_ASSERT_NXT(a_fill_counts, i_clk, i_rst_n, i_cmd.fill, r_cnt != '0 && r_fault)

endmodule

### sv/cpr_ctrl.sv
// sequencing state machine and result valid flag
// depends on cpr_pkg and the assertion macro header
`include "clock_page_replacement_unit_assert.svh"

module cpr_ctrl import cpr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (!i_sts.hit) begin
                    o_cmd.sweep_start = 1'b1;
                    n_state           = S_SWEEP;
                end else if (out_free) begin
                    o_cmd.hit_commit = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_SWEEP: begin
                if (i_sts.scan_ref) begin
                    o_cmd.sweep_step = 1'b1;
                end else if (out_free) begin
                    o_cmd.fill = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = (r_out_valid && !i_out_ready) || o_cmd.hit_commit || o_cmd.fill;
    end

    assign o_out_valid = r_out_valid;

    `CPR_ASSERT_NXT(a_accept_to_lookup, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_LOOKUP)
    `CPR_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, o_cmd.hit_commit || o_cmd.fill, out_free)
    `CPR_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, o_cmd.hit_commit || o_cmd.fill, r_out_valid && r_state == S_IDLE)

endmodule

### sv/clock_page_replacement_unit.sv
// top level of the clock page replacement unit
// depends on cpr_pkg, cpr_intf, cpr_ctrl and cpr_datapath
//
// Clock (second chance) page replacement over up to 16 frames. Each request
// carries a page number; the unit searches the frames in use for it by a
// parallel compare. A hit marks the frame referenced and dirty. A miss
// starts the clock hand sweep: one frame per cycle, every referenced frame
// passed has its bit cleared, and the page is loaded into the first
// unreferenced frame, after which the hand moves one past it. A request is
// taken in S_IDLE and looked up in S_LOOKUP; a hit then loads the result
// register, a fault goes on to S_SWEEP, where the single sweep pointer steps
// over each referenced frame (at most frames_in_use) before the fill. One
// request is worked on at a time; the result sits in an output register, so
// the next request is taken while the previous result still waits. The
// frames_in_use register (reset 16, 0 acts as 1, above 16 acts as 16) is
// written through i_cfg_we / i_cfg_wdata and must only change while the
// unit is idle. The fault count saturates at all ones.
module clock_page_replacement_unit import cpr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    cpr_req_if.sink          i_req,
    cpr_rsp_if.source        o_rsp
);

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: lookup, hand sweep, result handoff
    cpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // frame store, hand, fault counter and the result register
    cpr_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_page          (i_req.page),
        .i_last          (i_req.last),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_fault         (o_rsp.fault),
        .o_frame         (o_rsp.frame),
        .o_evicted_valid (o_rsp.evicted_valid),
        .o_evicted_page  (o_rsp.evicted_page),
        .o_evicted_dirty (o_rsp.evicted_dirty),
        .o_fault_total   (o_rsp.fault_total),
        .o_last_out      (o_rsp.last_out)
    );

endmodule

### sim/tb_top.sv
// self-checking testbench for clock_page_replacement_unit
// depends on cpr_pkg, cpr_intf and the unit's rtl; a built-in predictor gives the expected result of untyped rows
module tb_top import cpr_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               fault;
        logic [FRAME_W-1:0] frame;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic               evicted_dirty;
        logic [FAULT_W-1:0] fault_total;
        logic               last_out;
    } t_page_result;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [CNT_W-1:0]  frames;
        logic [PAGE_W-1:0] page;
        logic              last;
        bit                typed;
        t_page_result      result;
    } t_stim_row;

    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 140;
    localparam int HOLD_CYCLES = 300;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;

    cpr_req_if req_ch ();
    cpr_rsp_if rsp_ch ();

    clock_page_replacement_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    always #1 i_clk = ~i_clk;

    // predictor copy of the frame store and the hand
    logic [PAGE_W-1:0]  frame_pages [MAX_FRAMES];
    logic               frame_live  [MAX_FRAMES];
    logic               frame_ref   [MAX_FRAMES];
    logic               frame_mod   [MAX_FRAMES];
    int                 hand_pos;
    logic [FAULT_W-1:0] fault_cnt;
    logic [CNT_W-1:0]   frames_cfg;

    t_page_result pending_results [$];
    t_stim_row    directed_rows [$];

    int  error_count;
    int  requests_sent;
    int  results_seen;
    int  faults_seen;
    int  hits_seen;
    int  cfg_writes;
    bit  hold_rsp;

    function automatic int active_frames(logic [CNT_W-1:0] cfg);
        int n;
        n = cfg;
        if (n == 0) n = 1;
        if (n > MAX_FRAMES) n = MAX_FRAMES;
        return n;
    endfunction

    // one request against the predictor state: search, then sweep on a miss
    function automatic t_page_result predict_access(logic [PAGE_W-1:0] page, logic last);
        t_page_result r;
        int           n;
        int           h;
        int           i;
        bit           found;
        n = active_frames(frames_cfg);
        r = '0;
        r.last_out = last;
        found = 1'b0;
        for (i = 0; i < n; i++) begin
            if (!found && frame_live[i] && frame_pages[i] == page) begin
                frame_ref[i] = 1'b1;
                frame_mod[i] = 1'b1;
                r.frame = i[FRAME_W-1:0];
                found = 1'b1;
            end
        end
        if (!found) begin
            h = hand_pos;
            if (h >= n) h = 0;
            // second chance: clear reference bits until a clear one turns up
            for (i = 0; i < 2 * n; i++) begin
                if (!frame_ref[h]) break;
                frame_ref[h] = 1'b0;
                h = (h + 1) % n;
            end
            if (frame_live[h]) begin
                r.evicted_valid = 1'b1;
                r.evicted_page  = frame_pages[h];
                r.evicted_dirty = frame_mod[h];
            end
            frame_pages[h] = page;
            frame_live[h]  = 1'b1;
            frame_ref[h]   = 1'b1;
            frame_mod[h]   = 1'b0;
            r.fault = 1'b1;
            r.frame = h[FRAME_W-1:0];
            hand_pos = (h + 1) % n;
            if (fault_cnt != '1) fault_cnt++;
        end
        r.fault_total = fault_cnt;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_req(logic [PAGE_W-1:0] page, logic last);
        t_stim_row row;
        row = '{ROW_REQ, '0, page, last, 1'b0, '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_typed(logic [PAGE_W-1:0] page, logic last,
                                      t_page_result result);
        t_stim_row row;
        row = '{ROW_REQ, '0, page, last, 1'b1, result};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [CNT_W-1:0] frames);
        t_stim_row row;
        row = '{ROW_CFG, frames, '0, 1'b0, 1'b0, '0};
        directed_rows.push_back(row);
    endfunction

    // offer one request, hold it until taken, then record what it should give
    task automatic send_request(logic [PAGE_W-1:0] page, logic last, bit typed,
                                t_page_result typed_result, int gap);
        t_page_result predicted;
        req_ch.valid <= 1'b1;
        req_ch.page  <= page;
        req_ch.last  <= last;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = predict_access(page, last);
        pending_results.push_back(typed ? typed_result : predicted);
        requests_sent++;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge i_clk);
        // every request gives a result; the wait after the queue empties lets the unit settle
        repeat (4) @(posedge i_clk);
    endtask

    // frame count changes only with nothing in flight
    task automatic write_frames(logic [CNT_W-1:0] frames);
        req_ch.valid <= 1'b0;
        drain_results();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= frames;
        frames_cfg = frames;
        cfg_writes++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // result checker
    initial begin : result_check
        t_page_result seen;
        t_page_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                seen = '{rsp_ch.fault, rsp_ch.frame, rsp_ch.evicted_valid,
                         rsp_ch.evicted_page, rsp_ch.evicted_dirty,
                         rsp_ch.fault_total, rsp_ch.last_out};
                results_seen++;
                if (seen.fault) faults_seen++;
                else hits_seen++;
                if (pending_results.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: %p", seen);
                end else begin
                    want = pending_results.pop_front();
                    if (seen !== want) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("result %0d mismatch", results_seen);
                            $display("  expected %p", want);
                            $display("  actual   %p", seen);
                        end
                    end
                end
            end
        end
    end

    // result side backpressure, with one long hold-off on request
    initial begin : result_sink
        int  stall_left;
        bit  smooth;
        stall_left = 0;
        smooth = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_rsp) begin
                hold_rsp = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
                if (!smooth && $urandom_range(0, 2) == 0) stall_left = pick_gap();
            end
            if ($urandom_range(0, 199) == 0) smooth = !smooth;
        end
    end

    initial begin : run_limit
        #2000000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int               phase_cfg [PHASE_COUNT];
        int               p;
        int               k;
        int               n;
        int               base;
        int               span;
        int               wait_cyc;
        bit               quiet;
        logic [PAGE_W-1:0] page;
        logic             last;

        error_count   = 0;
        requests_sent = 0;
        results_seen  = 0;
        faults_seen   = 0;
        hits_seen     = 0;
        cfg_writes    = 0;
        hold_rsp      = 1'b0;
        foreach (frame_pages[i]) begin
            frame_pages[i] = '0;
            frame_live[i]  = 1'b0;
            frame_ref[i]   = 1'b0;
            frame_mod[i]   = 1'b0;
        end
        hand_pos   = 0;
        fault_cnt  = '0;
        frames_cfg = CNT_W'(MAX_FRAMES);

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        req_ch.valid <= 1'b0;
        req_ch.page  <= '0;
        req_ch.last  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        // page 0 right after reset must miss: the cleared store is empty
        add_typed(8'd0,   1'b0, '{1'b1, 4'd0, 1'b0, 8'd0, 1'b0, 32'd1, 1'b0});
        add_typed(8'd255, 1'b1, '{1'b1, 4'd1, 1'b0, 8'd0, 1'b0, 32'd2, 1'b1});
        add_typed(8'd0,   1'b0, '{1'b0, 4'd0, 1'b0, 8'd0, 1'b0, 32'd2, 1'b0});
        add_req(8'd255, 1'b0);
        // one frame: the hand sits past the count, sweep starts at frame 0
        add_cfg(5'd1);
        add_req(8'd7, 1'b0);
        add_req(8'd7, 1'b1);
        add_req(8'd8, 1'b0);
        // zero acts as one frame
        add_cfg(5'd0);
        add_req(8'd9, 1'b0);
        add_req(8'd9, 1'b0);
        // above the maximum acts as all frames; frame 1 kept its page
        add_cfg(5'd31);
        add_req(8'd255, 1'b0);
        add_req(8'd128, 1'b0);
        add_req(8'd64,  1'b1);
        add_req(8'd170, 1'b0);
        add_req(8'd85,  1'b0);
        add_req(8'd1,   1'b0);
        add_req(8'd2,   1'b0);
        add_cfg(5'd16);
        add_req(8'd3,   1'b0);
        add_req(8'd128, 1'b0);
        add_req(8'd4,   1'b0);
        // three frames, all referenced by the end: full second-chance pass
        add_cfg(5'd3);
        add_req(8'd200, 1'b0);
        add_req(8'd201, 1'b0);
        add_req(8'd202, 1'b0);
        add_req(8'd203, 1'b1);
        add_req(8'd201, 1'b0);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG)
                write_frames(directed_rows[r].frames);
            else
                send_request(directed_rows[r].page, directed_rows[r].last,
                             directed_rows[r].typed, directed_rows[r].result, pick_gap());
        end

        // random part: each phase a frame count, pages mostly from a small pool
        phase_cfg = '{16, 1, 5, 0, 31, 2, 16, 0};
        phase_cfg[7] = $urandom_range(3, 15);
        for (p = 0; p < PHASE_COUNT; p++) begin
            write_frames(CNT_W'(phase_cfg[p]));
            n = active_frames(CNT_W'(phase_cfg[p]));
            base = $urandom_range(0, 255);
            span = n + $urandom_range(0, n);
            quiet = (p == 5);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // the sink stalls for a long time while requests keep coming
                if (p == 2 && k == 3) hold_rsp = 1'b1;
                // pause until every outstanding result is back
                if (p == 4 && k == 70) begin
                    req_ch.valid <= 1'b0;
                    drain_results();
                end
                if ($urandom_range(0, 4) == 0) page = PAGE_W'($urandom_range(0, 255));
                else page = PAGE_W'(base + $urandom_range(0, span));
                last = ($urandom_range(0, 7) == 0);
                send_request(page, last, 1'b0, '0, quiet ? 0 : pick_gap());
            end
        end
        req_ch.valid <= 1'b0;

        for (wait_cyc = 0; pending_results.size() != 0 && wait_cyc < 20000; wait_cyc++)
            @(posedge i_clk);
        if (pending_results.size() != 0) begin
            error_count++;
            $display("%0d results never arrived", pending_results.size());
        end
        repeat (40) @(posedge i_clk);

        $display("%0d requests over %0d frame count writes", requests_sent, cfg_writes);
        $display("%0d faults, %0d hits, %0d errors", faults_seen, hits_seen, error_count);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
